/* design/fpse_pkg.sv */
// fpse_pkg: shared types, constants and helper functions for the front panel
// setpoint editor. No dependencies; every design file but fpse_checker imports it.
`timescale 1ns / 1ps

package fpse_pkg;

    localparam int BUTTON_COUNT = 11;
    localparam int PIN_W        = 16;

    // button bit positions
    localparam int BTN_TARGET = 0;
    localparam int BTN_LEFT   = 3;
    localparam int BTN_RIGHT  = 4;
    localparam int BTN_DEBUG  = 5;
    localparam int BTN_TIMER  = 6;
    localparam int BTN_EXT    = 7;
    localparam int BTN_LOAD   = 8;

    localparam logic [PIN_W-1:0] ENC_MASK    = 16'h0006;
    localparam logic [PIN_W-1:0] BUTTON_MASK = PIN_W'((32'd1 << BUTTON_COUNT) - 32'd1);

    // configuration register indexes
    localparam logic [7:0] CFG_CUR_LIMIT = 8'd0;
    localparam logic [7:0] CFG_UVP_LIMIT = 8'd1;

    localparam logic [9:0]  CUR_LIMIT_RESET = 10'd1000;
    localparam logic [13:0] UVP_LIMIT_RESET = 14'd9999;
    localparam logic [9:0]  CUR_SP_RESET    = 10'd60;
    localparam logic [13:0] UVP_SP_RESET    = 14'd1000;
    localparam logic [1:0]  CUR_CURSOR_RESET = 2'd3;
    localparam logic [1:0]  UVP_CURSOR_RESET = 2'd1;
    localparam logic [1:0]  CURSOR_MAX       = 2'd3;

    localparam logic signed [3:0] ACC_LOW  = -4'sd4;
    localparam logic signed [3:0] ACC_HIGH = 4'sd4;

    // floor(t * 65.536) = (t * CODE_MULT) >> CODE_SHIFT for t below 1000
    localparam logic [33:0] CODE_MULT  = 34'd8589935;
    localparam int          CODE_SHIFT = 17;
    localparam logic [9:0]  CODE_SAT_TENTHS = 10'd1000;

    typedef struct packed {
        logic [PIN_W-1:0]  prev_pins;
        logic signed [3:0] acc;
        logic [9:0]        cur_sp;
        logic [13:0]       uvp_sp;
        logic [15:0]       code;
        logic              load;
        logic              ext;
        logic              uvp_mode;
        logic              debug;
        logic [1:0]        cur_cursor;
        logic [1:0]        uvp_cursor;
    } state_t;

    typedef struct packed {
        logic [9:0]  set_current_tenths;
        logic [13:0] uvp_hundredths;
        logic [15:0] dac_code;
        logic        dac_write;
        logic        load_enabled;
        logic        external_sense;
        logic        editing_uvp;
        logic [1:0]  current_digit;
        logic [1:0]  uvp_digit;
        logic        debug_view;
        logic        timer_reset;
    } result_t;

    // quadrature step indexed by {old AB, new AB}
    function automatic logic signed [3:0] quad_delta(input logic [3:0] idx);
        logic signed [3:0] d;
        case (idx) inside
            4'd1, 4'd7, 4'd8, 4'd14:  d = 4'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = -4'sd1;
            default:                  d = 4'sd0;
        endcase
        return d;
    endfunction

    // digit step, same for both targets in their own units
    function automatic logic [9:0] step_of(input logic [1:0] cursor);
        logic [9:0] s;
        case (cursor)
            2'd0:    s = 10'd1000;
            2'd1:    s = 10'd100;
            2'd2:    s = 10'd10;
            default: s = 10'd1;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] code_of(input logic [9:0] tenths);
        logic [33:0] prod;
        logic [15:0] c;
        prod = {24'd0, tenths} * CODE_MULT;
        if (tenths >= CODE_SAT_TENTHS) begin
            c = 16'hFFFF;
        end else begin
            c = prod[CODE_SHIFT+15:CODE_SHIFT];
        end
        return c;
    endfunction

endpackage

/* design/fpse_in_stage.sv */
// fpse_in_stage: input register that holds one accepted pin snapshot.
// Depends on fpse_pkg.
`timescale 1ns / 1ps

module fpse_in_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [fpse_pkg::PIN_W-1:0] s_port_pins,
    input  logic                       advance,
    output logic                       full,
    output logic [fpse_pkg::PIN_W-1:0] pins
);
    import fpse_pkg::*;

    logic             full_reg;
    logic             full_next;
    logic [PIN_W-1:0] pins_reg;

    assign s_ready   = aresetn && (!full_reg || advance);
    assign full_next = (s_valid && s_ready) || (full_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pins_reg <= s_port_pins;
        end
    end

    assign full = full_reg;
    assign pins = pins_reg;

endmodule

/* design/fpse_step.sv */
// fpse_step: next state and result for one pin snapshot (encoder detents,
// clamped digit edits, converter code, buttons). Depends on fpse_pkg.
`timescale 1ns / 1ps

module fpse_step (
    input  fpse_pkg::state_t           st,
    input  logic [fpse_pkg::PIN_W-1:0] pins,
    input  logic [9:0]                 cur_limit,
    input  logic [13:0]                uvp_limit,
    output fpse_pkg::state_t           nx,
    output fpse_pkg::result_t          res
);
    import fpse_pkg::*;

    logic [PIN_W-1:0]   changed;
    logic [PIN_W-1:0]   pressed;
    logic signed [3:0]  acc_sum;
    logic               det_add;
    logic               det_sub;
    logic               cur_edit;
    logic               uvp_edit;
    logic [9:0]         step;
    logic signed [11:0] cur_sum;
    logic signed [15:0] uvp_sum;
    logic [9:0]         cur_clamped;
    logic [13:0]        uvp_clamped;
    logic [15:0]        code_new;
    logic               mode;
    logic [1:0]         cursor;

    always_comb begin
        nx      = st;
        changed = pins ^ st.prev_pins;
        pressed = changed & ~pins & ~ENC_MASK & BUTTON_MASK;

        acc_sum = st.acc;
        if (|(changed & ENC_MASK)) begin
            acc_sum = st.acc + quad_delta({st.prev_pins[2:1], pins[2:1]});
        end
        // a full detent backwards adds the step, forwards subtracts it
        det_add = (acc_sum <= ACC_LOW);
        det_sub = (acc_sum >= ACC_HIGH);
        nx.acc  = (det_add || det_sub) ? 4'sd0 : acc_sum;

        cur_edit = (det_add || det_sub) && !st.uvp_mode;
        uvp_edit = (det_add || det_sub) && st.uvp_mode;
        step     = step_of(st.uvp_mode ? st.uvp_cursor : st.cur_cursor);

        if (det_add) begin
            cur_sum = $signed({2'b00, st.cur_sp}) + $signed({2'b00, step});
            uvp_sum = $signed({2'b00, st.uvp_sp}) + $signed({6'd0, step});
        end else begin
            cur_sum = $signed({2'b00, st.cur_sp}) - $signed({2'b00, step});
            uvp_sum = $signed({2'b00, st.uvp_sp}) - $signed({6'd0, step});
        end

        if (cur_sum[11]) begin
            cur_clamped = 10'd0;
        end else if (cur_sum[10:0] > {1'b0, cur_limit}) begin
            cur_clamped = cur_limit;
        end else begin
            cur_clamped = cur_sum[9:0];
        end

        if (uvp_sum[15]) begin
            uvp_clamped = 14'd0;
        end else if (uvp_sum[14:0] > {1'b0, uvp_limit}) begin
            uvp_clamped = uvp_limit;
        end else begin
            uvp_clamped = uvp_sum[13:0];
        end

        if (cur_edit) begin
            nx.cur_sp = cur_clamped;
        end
        if (uvp_edit) begin
            nx.uvp_sp = uvp_clamped;
        end
        code_new     = code_of(nx.cur_sp);
        nx.prev_pins = pins;

        // buttons in ascending bit order: target toggle first, then cursor moves
        mode        = st.uvp_mode ^ pressed[BTN_TARGET];
        nx.uvp_mode = mode;
        cursor      = mode ? st.uvp_cursor : st.cur_cursor;
        if (pressed[BTN_LEFT] && (cursor != 2'd0)) begin
            cursor = cursor - 2'd1;
        end
        if (pressed[BTN_RIGHT] && (cursor != CURSOR_MAX)) begin
            cursor = cursor + 2'd1;
        end
        if (mode) begin
            nx.uvp_cursor = cursor;
        end else begin
            nx.cur_cursor = cursor;
        end

        nx.debug = st.debug ^ pressed[BTN_DEBUG];
        nx.ext   = st.ext ^ pressed[BTN_EXT];
        nx.load  = st.load ^ pressed[BTN_LOAD];

        if (pressed[BTN_LOAD]) begin
            nx.code = nx.load ? code_new : 16'd0;
        end else if (cur_edit) begin
            nx.code = code_new;
        end

        res.set_current_tenths = nx.cur_sp;
        res.uvp_hundredths     = nx.uvp_sp;
        res.dac_code           = nx.code;
        res.dac_write          = cur_edit || pressed[BTN_LOAD];
        res.load_enabled       = nx.load;
        res.external_sense     = nx.ext;
        res.editing_uvp        = nx.uvp_mode;
        res.current_digit      = nx.cur_cursor;
        res.uvp_digit          = nx.uvp_cursor;
        res.debug_view         = nx.debug;
        res.timer_reset        = pressed[BTN_TIMER];
    end

endmodule

/* design/fpse_out_stage.sv */
// fpse_out_stage: result register with valid/ready toward the consumer.
// Depends on fpse_pkg.
`timescale 1ns / 1ps

module fpse_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  fpse_pkg::result_t res_in,
    output logic              can_take,
    output logic              m_valid,
    input  logic              m_ready,
    output fpse_pkg::result_t res_out
);
    import fpse_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_take   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

/* design/front_panel_setpoint_editor_unit.sv */
// Front panel setpoint editor: input register, single-pass step logic, result register.
// An accepted item waits in the input register until the result register can take it.
// Throughput: one item per cycle unless m_ready stalls; each move frees the input side.
// State is updated when an item moves from the input register to the result register.
// Reset (aresetn low, synchronous) empties both registers, restores setpoints, cursors,
// flags and limits to their power-up values; no clearing pass is needed.
`timescale 1ns / 1ps

module front_panel_setpoint_editor_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [fpse_pkg::PIN_W-1:0] s_port_pins,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [9:0]                 m_set_current_tenths,
    output logic [13:0]                m_uvp_hundredths,
    output logic [15:0]                m_dac_code,
    output logic                       m_dac_write,
    output logic                       m_load_enabled,
    output logic                       m_external_sense,
    output logic                       m_editing_uvp,
    output logic [1:0]                 m_current_digit,
    output logic [1:0]                 m_uvp_digit,
    output logic                       m_debug_view,
    output logic                       m_timer_reset,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [7:0]                 cfg_index,
    input  logic [15:0]                cfg_data
);
    import fpse_pkg::*;

    logic             full;
    logic [PIN_W-1:0] pins;
    logic             can_take;
    logic             advance;
    state_t           st_reg;
    state_t           st_next;
    result_t          res_step;
    result_t          res_out;
    logic [9:0]       cur_limit_reg;
    logic [13:0]      uvp_limit_reg;

    assign advance   = full && can_take;
    assign cfg_ready = aresetn;

    fpse_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_port_pins (s_port_pins),
        .advance     (advance),
        .full        (full),
        .pins        (pins)
    );

    fpse_step u_step (
        .st        (st_reg),
        .pins      (pins),
        .cur_limit (cur_limit_reg),
        .uvp_limit (uvp_limit_reg),
        .nx        (st_next),
        .res       (res_step)
    );

    fpse_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res_in   (res_step),
        .can_take (can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .res_out  (res_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.prev_pins  <= '1;
            st_reg.acc        <= 4'sd0;
            st_reg.cur_sp     <= CUR_SP_RESET;
            st_reg.uvp_sp     <= UVP_SP_RESET;
            st_reg.code       <= 16'd0;
            st_reg.load       <= 1'b0;
            st_reg.ext        <= 1'b0;
            st_reg.uvp_mode   <= 1'b0;
            st_reg.debug      <= 1'b0;
            st_reg.cur_cursor <= CUR_CURSOR_RESET;
            st_reg.uvp_cursor <= UVP_CURSOR_RESET;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_limit_reg <= CUR_LIMIT_RESET;
            uvp_limit_reg <= UVP_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CUR_LIMIT: cur_limit_reg <= cfg_data[9:0];
                CFG_UVP_LIMIT: uvp_limit_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    assign m_set_current_tenths = res_out.set_current_tenths;
    assign m_uvp_hundredths     = res_out.uvp_hundredths;
    assign m_dac_code           = res_out.dac_code;
    assign m_dac_write          = res_out.dac_write;
    assign m_load_enabled       = res_out.load_enabled;
    assign m_external_sense     = res_out.external_sense;
    assign m_editing_uvp        = res_out.editing_uvp;
    assign m_current_digit      = res_out.current_digit;
    assign m_uvp_digit          = res_out.uvp_digit;
    assign m_debug_view         = res_out.debug_view;
    assign m_timer_reset        = res_out.timer_reset;

endmodule

/* design/fpse_checker.sv */
// fpse_checker: port-level checks for the setpoint editor, bound to the top level.
// Depends on front_panel_setpoint_editor_unit.
`timescale 1ns / 1ps

module fpse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [9:0]  m_set_current_tenths,
    input logic [15:0] m_dac_code,
    input logic        m_dac_write
);

    // nothing shows on the output right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dac_code)
            && $stable(m_set_current_tenths))
        else $error("stalled result changed");

    // a new result only follows an item accepted and held in the input register
    a_rise_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without accepted item");

    // a written code at or above the full-scale setpoint saturates, or is zero for load off
    a_code_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dac_write && (m_set_current_tenths >= 10'd1000)
            |-> (m_dac_code == 16'hFFFF) || (m_dac_code == 16'd0))
        else $error("converter code not saturated");

endmodule

bind front_panel_setpoint_editor_unit fpse_checker u_fpse_checker (.*);

/* verif/front_panel_setpoint_editor_unit_tb.sv */
// front_panel_setpoint_editor_unit_tb: self-checking bench for the front panel setpoint editor.
// Predicts every readout from the pin items sent in and compares it field by field.
// Depends on fpse_pkg and front_panel_setpoint_editor_unit.
`timescale 1ns / 1ps

module front_panel_setpoint_editor_unit_tb;
    import fpse_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 210;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [15:0] s_port_pins = 16'hFFFF;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [9:0]  m_set_current_tenths;
    logic [13:0] m_uvp_hundredths;
    logic [15:0] m_dac_code;
    logic        m_dac_write;
    logic        m_load_enabled;
    logic        m_external_sense;
    logic        m_editing_uvp;
    logic [1:0]  m_current_digit;
    logic [1:0]  m_uvp_digit;
    logic        m_debug_view;
    logic        m_timer_reset;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index   = 8'd0;
    logic [15:0] cfg_data    = 16'd0;

    // predicted editor state
    logic [15:0] pins_last  = 16'hFFFF;
    int          detent_acc = 0;
    logic [9:0]  cur_tenths = 10'd60;
    logic [13:0] uvp_centi  = 14'd1000;
    logic [15:0] conv_code  = 16'd0;
    logic        load_on    = 1'b0;
    logic        ext_on     = 1'b0;
    logic        uvp_edit   = 1'b0;
    logic        debug_on   = 1'b0;
    logic [1:0]  cur_pos    = 2'd3;
    logic [1:0]  uvp_pos    = 2'd1;
    logic [9:0]  lim_cur    = 10'd1000;
    logic [13:0] lim_uvp    = 14'd9999;

    result_t     pending_readouts[$];
    int          fail_count   = 0;
    int          quiet_cycles = 0;

    // stimulus control
    logic [15:0] drv_pins   = 16'hFFFF;
    bit          spin_cw    = 1'b1;
    bit          idle_on    = 1'b1;
    bit          hold_req   = 1'b0;
    int          stall_left = 0;
    int          hold_left  = 0;
    bit          hold_armed = 1'b1;

    front_panel_setpoint_editor_unit uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_port_pins          (s_port_pins),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_set_current_tenths (m_set_current_tenths),
        .m_uvp_hundredths     (m_uvp_hundredths),
        .m_dac_code           (m_dac_code),
        .m_dac_write          (m_dac_write),
        .m_load_enabled       (m_load_enabled),
        .m_external_sense     (m_external_sense),
        .m_editing_uvp        (m_editing_uvp),
        .m_current_digit      (m_current_digit),
        .m_uvp_digit          (m_uvp_digit),
        .m_debug_view         (m_debug_view),
        .m_timer_reset        (m_timer_reset),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // next encoder state along the gray sequence, clockwise or back
    function automatic logic [1:0] gray_step(input logic [1:0] ab, input bit cw);
        logic [1:0] nxt;
        case (ab)
            2'd0:    nxt = cw ? 2'd1 : 2'd2;
            2'd1:    nxt = cw ? 2'd3 : 2'd0;
            2'd2:    nxt = cw ? 2'd0 : 2'd3;
            default: nxt = cw ? 2'd2 : 2'd1;
        endcase
        return nxt;
    endfunction

    function automatic int digit_step(input logic [1:0] cursor);
        int s;
        case (cursor)
            2'd0:    s = 1000;
            2'd1:    s = 100;
            2'd2:    s = 10;
            default: s = 1;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] tenths_to_code(input logic [9:0] t);
        int unsigned scaled;
        scaled = (int'(t) * 65536) / 1000;
        return (scaled > 65535) ? 16'hFFFF : 16'(scaled);
    endfunction

    // one detent on the edited target; returns 1 when the converter code was written
    function automatic bit nudge_target(input int dir);
        int v;
        if (uvp_edit) begin
            v = int'(uvp_centi) + dir * digit_step(uvp_pos);
            uvp_centi = (v < 0) ? 14'd0 : (v > int'(lim_uvp)) ? lim_uvp : 14'(v);
            return 1'b0;
        end
        v = int'(cur_tenths) + dir * digit_step(cur_pos);
        cur_tenths = (v < 0) ? 10'd0 : (v > int'(lim_cur)) ? lim_cur : 10'(v);
        conv_code  = tenths_to_code(cur_tenths);
        return 1'b1;
    endfunction

    function automatic result_t predict_readout(input logic [15:0] pins);
        result_t     r;
        logic [15:0] changed;
        logic [15:0] pressed;
        bit          wrote;
        bit          timer_hit;
        changed   = pins ^ pins_last;
        wrote     = 1'b0;
        timer_hit = 1'b0;
        if ((changed & ENC_MASK) != 16'd0) begin
            if (pins[2:1] == gray_step(pins_last[2:1], 1'b1)) begin
                detent_acc++;
            end else if (pins[2:1] == gray_step(pins_last[2:1], 1'b0)) begin
                detent_acc--;
            end
            // counterclockwise detent adds the step, clockwise subtracts it
            if (detent_acc <= -4) begin
                detent_acc = 0;
                wrote = nudge_target(1);
            end else if (detent_acc >= 4) begin
                detent_acc = 0;
                wrote = nudge_target(-1);
            end
        end
        pins_last = pins;
        pressed = changed & ~pins & ~ENC_MASK;
        for (int b = 0; b < BUTTON_COUNT && b < 16; b++) begin
            if (pressed[b]) begin
                case (b)
                    BTN_TARGET: uvp_edit = ~uvp_edit;
                    BTN_LEFT: begin
                        if (uvp_edit) begin
                            if (uvp_pos != 2'd0) uvp_pos--;
                        end else begin
                            if (cur_pos != 2'd0) cur_pos--;
                        end
                    end
                    BTN_RIGHT: begin
                        if (uvp_edit) begin
                            if (uvp_pos != 2'd3) uvp_pos++;
                        end else begin
                            if (cur_pos != 2'd3) cur_pos++;
                        end
                    end
                    BTN_DEBUG: debug_on = ~debug_on;
                    BTN_TIMER: timer_hit = 1'b1;
                    BTN_EXT:   ext_on = ~ext_on;
                    BTN_LOAD: begin
                        load_on   = ~load_on;
                        conv_code = load_on ? tenths_to_code(cur_tenths) : 16'd0;
                        wrote     = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        r.set_current_tenths = cur_tenths;
        r.uvp_hundredths     = uvp_centi;
        r.dac_code           = conv_code;
        r.dac_write          = wrote;
        r.load_enabled       = load_on;
        r.external_sense     = ext_on;
        r.editing_uvp        = uvp_edit;
        r.current_digit      = cur_pos;
        r.uvp_digit          = uvp_pos;
        r.debug_view         = debug_on;
        r.timer_reset        = timer_hit;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // readouts are checked before the item of the same edge is predicted
    always @(posedge aclk) begin : scoreboard
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_readouts.size() == 0) begin
                    $error("readout with no item pending");
                    fail_count++;
                end else begin
                    want = pending_readouts.pop_front();
                    check_field("set_current_tenths", want.set_current_tenths,
                                m_set_current_tenths);
                    check_field("uvp_hundredths", want.uvp_hundredths, m_uvp_hundredths);
                    check_field("dac_code", want.dac_code, m_dac_code);
                    check_field("dac_write", want.dac_write, m_dac_write);
                    check_field("load_enabled", want.load_enabled, m_load_enabled);
                    check_field("external_sense", want.external_sense, m_external_sense);
                    check_field("editing_uvp", want.editing_uvp, m_editing_uvp);
                    check_field("current_digit", want.current_digit, m_current_digit);
                    check_field("uvp_digit", want.uvp_digit, m_uvp_digit);
                    check_field("debug_view", want.debug_view, m_debug_view);
                    check_field("timer_reset", want.timer_reset, m_timer_reset);
                end
            end
            if (s_valid && s_ready) pending_readouts.push_back(predict_readout(s_port_pins));
        end
    end

    // receiver: random stall bursts plus one long hold when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_req && hold_armed) begin
            hold_left  <= HOLD_CYCLES - 1;
            hold_armed <= 1'b0;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 13);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("front_panel_setpoint_editor_unit: mismatch");
            $finish;
        end
    end

    task automatic send_pins(input logic [15:0] pins);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_port_pins <= pins;
        drv_pins     = pins;
        do @(posedge aclk); while (!s_ready);
    endtask

    // mostly real knob turns and button presses, some raw noise
    function automatic logic [15:0] next_pins(input logic [15:0] last);
        logic [15:0] pins;
        logic [1:0]  ab;
        int          roll;
        int          k;
        if ($urandom_range(0, 99) < 8) return 16'($urandom_range(0, 65535));
        ab   = last[2:1];
        pins = ($urandom_range(0, 4) == 0) ? last : 16'hFFFF;
        if ($urandom_range(0, 9) == 0) spin_cw = ~spin_cw;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            ab = gray_step(ab, spin_cw);
        end else if (roll < 64) begin
            ab = ~ab;   // skipped state, not a valid transition
        end
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 13);
            pins[(k == 0) ? 0 : k + 2] = 1'b0;
        end
        if ($urandom_range(0, 19) == 0) pins[$urandom_range(0, 15)] = 1'b0;
        pins[2:1] = ab;
        return pins;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_pins(next_pins(drv_pins));
    endtask

    task automatic write_limit_reg(input logic [7:0] idx, input logic [15:0] data);
        s_valid <= 1'b0;
        // let the scoreboard queue the item accepted at this edge
        @(posedge aclk);
        while (pending_readouts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_CUR_LIMIT) begin
            lim_cur = data[9:0];
        end else if (idx == CFG_UVP_LIMIT) begin
            lim_uvp = data[13:0];
        end
    endtask

    task automatic test_pin_extremes();
        send_pins(16'h0000);
        send_pins(16'hFFFF);
    endtask

    // each non-encoder bit pressed alone, then target toggle and left press in the same item
    task automatic test_each_button();
        for (int b = 0; b < 16; b++) begin
            if (b != 1 && b != 2) send_pins(16'hFFFF & ~(16'd1 << b));
        end
        send_pins(16'hFFFF);
        send_pins(16'hFFFF & ~((16'd1 << BTN_TARGET) | (16'd1 << BTN_LEFT)));
    endtask

    task automatic test_encoder_detents();
        logic [15:0] pins;
        pins = 16'hFFFF;
        pins[2:1] = drv_pins[2:1];
        repeat (4) begin
            pins[2:1] = gray_step(pins[2:1], 1'b1);
            send_pins(pins);
        end
        repeat (4) begin
            pins[2:1] = gray_step(pins[2:1], 1'b0);
            send_pins(pins);
        end
        pins[2:1] = ~pins[2:1];
        send_pins(pins);
    endtask

    task automatic test_limit_phase(input logic [15:0] cur_lim, input logic [15:0] uvp_lim);
        write_limit_reg(CFG_CUR_LIMIT, cur_lim);
        write_limit_reg(CFG_UVP_LIMIT, uvp_lim);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_unmapped_register();
        write_limit_reg(8'hFF, 16'hFFFF);
        write_limit_reg(8'($urandom_range(2, 254)), 16'($urandom_range(0, 65535)));
        run_random(30);
    endtask

    // receiver holds off while items keep coming, so the input side stalls
    task automatic test_output_backpressure();
        idle_on  <= 1'b0;
        hold_req <= 1'b1;
        run_random(40);
        hold_req <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_pin_extremes();
        test_each_button();
        test_encoder_detents();
        test_limit_phase(16'hFFFF, 16'hFFFF);
        test_limit_phase(16'd0, 16'd0);
        test_limit_phase(16'd1000, 16'd9999);
        test_limit_phase(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 16383)));
        test_unmapped_register();
        test_limit_phase(16'd5, 16'd37);
        test_output_backpressure();
        idle_on <= 1'b0;
        test_limit_phase(16'd999, 16'd5000);
        s_valid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("front_panel_setpoint_editor_unit: match");
        end else begin
            $display("front_panel_setpoint_editor_unit: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
design/fpse_pkg.sv
design/fpse_in_stage.sv
design/fpse_step.sv
design/fpse_out_stage.sv
design/front_panel_setpoint_editor_unit.sv
design/fpse_checker.sv
verif/front_panel_setpoint_editor_unit_tb.sv
